// File: hw/rtl/sfrc_pkg.sv
// Shared types, constants and CRC helpers for the serial frame receiver/checker.
// No dependencies; the top level refers to everything here by scoped name.
`timescale 1ns / 1ps

package sfrc_pkg;

   // Frame buffer depth; a frame that grows past it is dropped.
   localparam int BUFFER_BYTES = 64;
   localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);
   localparam int LEN_W        = 9;   // 4 + 255 for the longest sensor frame

   localparam int DATA_W   = 8;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = 16;
   localparam int MAGIC_W  = 32;
   localparam int OFFS_W   = 5;
   localparam int CRC8_W   = 8;
   localparam int CRC16_W  = 16;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_TUSER_W = 4;

   // Header bytes
   localparam logic [DATA_W-1:0] HDR_CTRL   = 8'hFA;
   localparam logic [DATA_W-1:0] HDR_TUNE   = 8'hFB;
   localparam logic [DATA_W-1:0] HDR_SENSOR = 8'hFC;
   localparam logic [DATA_W-1:0] HDR_CALIB  = 8'hEE;
   localparam logic [DATA_W-1:0] HDR_DIRECT = 8'hEF;

   localparam logic [LEN_W-1:0]  SHORT_LEN       = 9'd2;
   localparam logic [LEN_W-1:0]  TUNE_LEN        = 9'd33;
   localparam logic [LEN_W-1:0]  SENSOR_HDR_LEN  = 9'd3;
   localparam logic [LEN_W-1:0]  SENSOR_OVERHEAD = 9'd4;
   localparam logic [COUNT_W-1:0] SENSOR_LEN_CNT = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] TUNE_CRC_SPAN  = COUNT_W'(30);
   localparam logic [DATA_W-1:0] TUNE_TAIL       = 8'hFE;

   localparam logic [CRC8_W-1:0]  CRC8_POLY  = 8'h07;
   localparam logic [CRC16_W-1:0] CRC16_POLY = 16'h1021;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_WORD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_OFFSET = 2'd1;

   localparam logic [MAGIC_W-1:0] MAGIC_WORD_RST   = 32'h40490FDA;
   localparam logic [OFFS_W-1:0]  MAGIC_OFFSET_RST = 5'd26;

   typedef enum logic [2:0] {
      KIND_CTRL   = 3'd0,
      KIND_TUNE   = 3'd1,
      KIND_SENSOR = 3'd2,
      KIND_CALIB  = 3'd3,
      KIND_DIRECT = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_MAGIC     = 3'd1,
      ST_TAIL      = 3'd2,
      ST_CRC16     = 3'd3,
      ST_CRC8      = 3'd4,
      ST_OVERFLOW  = 3'd5
   } status_type;

   typedef struct packed {
      logic               consumed;
      kind_type           frame_kind;
      logic [IDX_W-1:0]   byte_index;
      logic [DATA_W-1:0]  byte_value;
      logic               frame_end;
      status_type         status;
      logic [CNT_W-1:0]   good_frames;
      logic [CNT_W-1:0]   bad_frames;
   } rsp_type;

   function automatic logic [CRC8_W-1:0] crc8_next(input logic [CRC8_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
      logic [CRC8_W-1:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[CRC8_W-1] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [CRC16_W-1:0] crc16_next(input logic [CRC16_W-1:0] crc,
                                                     input logic [DATA_W-1:0] b);
      logic [CRC16_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[CRC16_W-1] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/serial_frame_receiver_checker_top.sv
// Serial frame receiver/checker: header decode, running CRCs, end-of-frame checks.
// Depends on sfrc_pkg.
`timescale 1ns / 1ps

// One received byte per request, one result per request, one request per clock
// sustained while rsp_tready keeps up: the whole frame update (header decode, CRC-8
// and CRC-16 byte steps, magic capture and end checks) sits between the request
// handshake and the result register. A two-entry result stage (output register plus
// skid) keeps req_tready high while a single result waits on rsp_tready.
// Headers 0xFA/0xEE/0xEF open 2-byte frames, 0xFB a 33-byte tuning frame and 0xFC
// a sensor frame of 4 + length bytes; a frame past the 64-byte buffer is dropped
// and its next byte comes back unconsumed with overflow status. Write csr_* only
// while no request is in flight.
module serial_frame_receiver_checker_top (
   input  logic                                clock,
   input  logic                                reset,
   // request: [7:0] rx_byte
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sfrc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // response: [5:0] byte_index, [13:6] byte_value, [16:14] status,
   // [32:17] good_frames, [48:33] bad_frames, [55:49] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sfrc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // response user: [0] consumed, [3:1] frame_kind
   output logic [sfrc_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   output logic                                rsp_tlast,
   // configuration write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sfrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfrc_pkg::MAGIC_W-1:0]        csr_data
);

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_CTRL   = 6'b000010,
      PH_TUNE   = 6'b000100,
      PH_SENSOR = 6'b001000,
      PH_CALIB  = 6'b010000,
      PH_DIRECT = 6'b100000
   } phase_type;

   localparam int COUNT_W = sfrc_pkg::COUNT_W;
   localparam int LEN_W   = sfrc_pkg::LEN_W;

   // configuration
   logic [sfrc_pkg::MAGIC_W-1:0]  magic_word_ff;
   logic [sfrc_pkg::OFFS_W-1:0]   magic_offset_ff;

   // frame state
   phase_type                     phase_ff, phase_in;
   logic [COUNT_W-1:0]            byte_count_ff, byte_count_in;
   logic [LEN_W-1:0]              expected_length_ff, expected_length_in;
   logic [sfrc_pkg::CRC8_W-1:0]   crc8_ff, crc8_in;
   logic [sfrc_pkg::CRC16_W-1:0]  crc16_ff, crc16_in;
   logic [sfrc_pkg::MAGIC_W-1:0]  captured_magic_ff, captured_magic_in;
   logic [sfrc_pkg::CRC16_W-1:0]  captured_crc16_ff, captured_crc16_in;
   logic [sfrc_pkg::CNT_W-1:0]    good_count_ff, good_count_in;
   logic [sfrc_pkg::CNT_W-1:0]    bad_count_ff, bad_count_in;

   // result stage
   sfrc_pkg::rsp_type             res;
   sfrc_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   sfrc_pkg::rsp_type             skid_data_ff, skid_data_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          skid_valid_ff, skid_valid_in;

   logic                          req_accept;
   logic [sfrc_pkg::DATA_W-1:0]   b;
   logic [COUNT_W-1:0]            pos;
   logic [COUNT_W-1:0]            magic_diff;
   logic                          in_window;
   logic                          hit;
   logic [LEN_W-1:0]              hdr_len;
   phase_type                     hdr_phase;
   sfrc_pkg::kind_type            hdr_kind;
   sfrc_pkg::kind_type            cur_kind;
   sfrc_pkg::status_type          st;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign b          = req_tdata[sfrc_pkg::DATA_W-1:0];
   assign pos        = byte_count_ff;

   // magic window: bytes offset .. offset+3, little-endian
   assign magic_diff = pos - COUNT_W'(magic_offset_ff);
   assign in_window  = (pos >= COUNT_W'(magic_offset_ff)) && (magic_diff < COUNT_W'(4));

   always_comb begin
      hit       = 1'b1;
      hdr_len   = sfrc_pkg::SHORT_LEN;
      hdr_phase = PH_CTRL;
      hdr_kind  = sfrc_pkg::KIND_CTRL;
      case (b)
         sfrc_pkg::HDR_CTRL: begin
            hdr_phase = PH_CTRL;
            hdr_kind  = sfrc_pkg::KIND_CTRL;
         end
         sfrc_pkg::HDR_TUNE: begin
            hdr_phase = PH_TUNE;
            hdr_kind  = sfrc_pkg::KIND_TUNE;
            hdr_len   = sfrc_pkg::TUNE_LEN;
         end
         sfrc_pkg::HDR_SENSOR: begin
            hdr_phase = PH_SENSOR;
            hdr_kind  = sfrc_pkg::KIND_SENSOR;
            hdr_len   = sfrc_pkg::SENSOR_HDR_LEN;
         end
         sfrc_pkg::HDR_CALIB: begin
            hdr_phase = PH_CALIB;
            hdr_kind  = sfrc_pkg::KIND_CALIB;
         end
         sfrc_pkg::HDR_DIRECT: begin
            hdr_phase = PH_DIRECT;
            hdr_kind  = sfrc_pkg::KIND_DIRECT;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (phase_ff)
         PH_TUNE:   cur_kind = sfrc_pkg::KIND_TUNE;
         PH_SENSOR: cur_kind = sfrc_pkg::KIND_SENSOR;
         PH_CALIB:  cur_kind = sfrc_pkg::KIND_CALIB;
         PH_DIRECT: cur_kind = sfrc_pkg::KIND_DIRECT;
         default:   cur_kind = sfrc_pkg::KIND_CTRL;
      endcase
   end

   // frame update for the byte in the request
   always_comb begin
      phase_in           = phase_ff;
      byte_count_in      = byte_count_ff;
      expected_length_in = expected_length_ff;
      crc8_in            = crc8_ff;
      crc16_in           = crc16_ff;
      captured_magic_in  = captured_magic_ff;
      captured_crc16_in  = captured_crc16_ff;
      good_count_in      = good_count_ff;
      bad_count_in       = bad_count_ff;
      st                 = sfrc_pkg::ST_OK;

      res.consumed   = 1'b0;
      res.frame_kind = sfrc_pkg::KIND_CTRL;
      res.byte_index = '0;
      res.byte_value = b;
      res.frame_end  = 1'b0;
      res.status     = sfrc_pkg::ST_OK;

      if (req_accept) begin
         if (phase_ff == PH_IDLE) begin
            if (hit) begin
               res.consumed       = 1'b1;
               res.frame_kind     = hdr_kind;
               phase_in           = hdr_phase;
               byte_count_in      = COUNT_W'(1);
               expected_length_in = hdr_len;
               crc8_in            = sfrc_pkg::crc8_next('0, b);
               crc16_in           = sfrc_pkg::crc16_next('0, b);
               captured_magic_in  = (magic_offset_ff == '0) ?
                                    sfrc_pkg::MAGIC_W'(b) : '0;
               captured_crc16_in  = '0;
            end
         end else begin
            res.frame_kind = cur_kind;
            if (byte_count_ff >= COUNT_W'(sfrc_pkg::BUFFER_BYTES)) begin
               // dropped: frame already fills the buffer
               res.byte_index = byte_count_ff[sfrc_pkg::IDX_W-1:0];
               res.frame_end  = 1'b1;
               res.status     = sfrc_pkg::ST_OVERFLOW;
               phase_in       = PH_IDLE;
               byte_count_in  = '0;
            end else begin
               res.consumed   = 1'b1;
               res.byte_index = pos[sfrc_pkg::IDX_W-1:0];
               byte_count_in  = pos + COUNT_W'(1);
               if (cur_kind == sfrc_pkg::KIND_SENSOR &&
                   byte_count_in == sfrc_pkg::SENSOR_LEN_CNT) begin
                  expected_length_in = sfrc_pkg::SENSOR_OVERHEAD + LEN_W'(b);
               end
               if (cur_kind == sfrc_pkg::KIND_TUNE) begin
                  if (in_window) begin
                     captured_magic_in[magic_diff[1:0]*8 +: 8] = b;
                  end
                  if (pos == sfrc_pkg::TUNE_CRC_SPAN) begin
                     captured_crc16_in = {8'h00, b};
                  end else if (pos == sfrc_pkg::TUNE_CRC_SPAN + COUNT_W'(1)) begin
                     captured_crc16_in[15:8] = b;
                  end
               end
               if (LEN_W'(byte_count_in) >= expected_length_in) begin
                  res.frame_end = 1'b1;
                  phase_in      = PH_IDLE;
                  if (cur_kind == sfrc_pkg::KIND_TUNE) begin
                     if (captured_magic_in != magic_word_ff) begin
                        st = sfrc_pkg::ST_MAGIC;
                     end else if (b != sfrc_pkg::TUNE_TAIL) begin
                        st = sfrc_pkg::ST_TAIL;
                     end else if (captured_crc16_in != crc16_ff) begin
                        st = sfrc_pkg::ST_CRC16;
                     end
                  end else if (cur_kind == sfrc_pkg::KIND_SENSOR) begin
                     if (crc8_ff != b) begin
                        st = sfrc_pkg::ST_CRC8;
                     end
                  end
                  res.status = st;
                  if (st == sfrc_pkg::ST_OK) begin
                     good_count_in = good_count_ff + sfrc_pkg::CNT_W'(1);
                  end else begin
                     bad_count_in = bad_count_ff + sfrc_pkg::CNT_W'(1);
                  end
               end
               crc8_in = sfrc_pkg::crc8_next(crc8_ff, b);
               if (pos < sfrc_pkg::TUNE_CRC_SPAN) begin
                  crc16_in = sfrc_pkg::crc16_next(crc16_ff, b);
               end
            end
         end
      end

      res.good_frames = good_count_in;
      res.bad_frames  = bad_count_in;
   end

   // result register with skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_data_in  = res;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in  = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         byte_count_ff      <= '0;
         expected_length_ff <= '0;
         crc8_ff            <= '0;
         crc16_ff           <= '0;
         captured_magic_ff  <= '0;
         captured_crc16_ff  <= '0;
         good_count_ff      <= '0;
         bad_count_ff       <= '0;
         rsp_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         byte_count_ff      <= byte_count_in;
         expected_length_ff <= expected_length_in;
         crc8_ff            <= crc8_in;
         crc16_ff           <= crc16_in;
         captured_magic_ff  <= captured_magic_in;
         captured_crc16_ff  <= captured_crc16_in;
         good_count_ff      <= good_count_in;
         bad_count_ff       <= bad_count_in;
         rsp_valid_ff       <= rsp_valid_in;
         skid_valid_ff      <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff   <= sfrc_pkg::MAGIC_WORD_RST;
         magic_offset_ff <= sfrc_pkg::MAGIC_OFFSET_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sfrc_pkg::CSR_MAGIC_WORD:   magic_word_ff   <= csr_data;
            sfrc_pkg::CSR_MAGIC_OFFSET: magic_offset_ff <= csr_data[sfrc_pkg::OFFS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_data_ff.frame_end;
   assign rsp_tuser  = {rsp_data_ff.frame_kind, rsp_data_ff.consumed};
   assign rsp_tdata  = {7'b0, rsp_data_ff.bad_frames, rsp_data_ff.good_frames,
                        rsp_data_ff.status, rsp_data_ff.byte_value,
                        rsp_data_ff.byte_index};

   // skid entry only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid without output entry");

   a_count_in_frame: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |->
         (byte_count_ff != '0) &&
         (byte_count_ff <= COUNT_W'(sfrc_pkg::BUFFER_BYTES)))
      else $error("byte count out of range inside a frame");

   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(good_count_ff) && $stable(bad_count_ff))
      else $error("frame counters moved without a request");

   a_drop_unconsumed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == sfrc_pkg::ST_OVERFLOW) |->
         (rsp_data_ff.frame_end && !rsp_data_ff.consumed))
      else $error("overflow result must end the frame and not consume");

endmodule

// File: tb/testbench.sv
// Self-checking bench for serial_frame_receiver_checker_top: drives received bytes,
// predicts every result with a local frame parser and compares field by field.
// Depends on sfrc_pkg and the top level under test.
`timescale 1ns / 1ps

module testbench;
   import sfrc_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_ITEMS = 150;
   localparam int TIMEOUT_NS   = 5_000_000;
   localparam int MAX_PRINTS   = 100;

   localparam int TUNE_BYTES  = 33;
   localparam int CRC16_SPAN  = 30;
   localparam int SENSOR_FIT  = 60;   // largest payload that still fits the buffer

   // indexes past the two real registers; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum {FAULT_NONE, FAULT_MAGIC, FAULT_TAIL, FAULT_CRC, FAULT_GARBLE} tune_fault_type;
   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_W-1:0]    req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]    rsp_tdata;
   logic [RSP_TUSER_W-1:0]    rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index  = '0;
   logic [MAGIC_W-1:0]        csr_data   = '0;

   serial_frame_receiver_checker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- parser copy
   logic [MAGIC_W-1:0] cfg_magic;
   logic [OFFS_W-1:0]  cfg_offset;
   logic               in_frame;
   kind_type           cur_kind;
   int unsigned        fill_cnt;
   int unsigned        frame_len;
   logic [7:0]         crc8_acc;
   logic [15:0]        crc16_acc;
   logic [31:0]        magic_acc;
   logic [15:0]        crc16_rx;
   logic [15:0]        good_cnt;
   logic [15:0]        bad_cnt;

   rsp_type pending_results[$];
   int      mismatch_count = 0;
   int      sent_items = 0;
   int      burst_left = 0;
   logic [7:0] frame_q[$];

   function automatic logic [7:0] crc8_of(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ b[i];
         c  = {c[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
      end
      return c;
   endfunction

   function automatic logic [15:0] crc16_of(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC16_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic void parser_reset();
      cfg_magic  = MAGIC_WORD_RST;
      cfg_offset = MAGIC_OFFSET_RST;
      in_frame   = 1'b0;
      cur_kind   = KIND_CTRL;
      fill_cnt   = 0;
      frame_len  = 0;
      crc8_acc   = '0;
      crc16_acc  = '0;
      magic_acc  = '0;
      crc16_rx   = '0;
      good_cnt   = '0;
      bad_cnt    = '0;
   endfunction

   function automatic rsp_type parse_byte(input logic [7:0] b);
      rsp_type     r;
      kind_type    k;
      int unsigned hdr_len;
      int unsigned pos;
      r = '0;
      r.byte_value = b;
      if (!in_frame) begin
         k = KIND_CTRL;
         hdr_len = 0;
         case (b)
            HDR_CTRL:   begin k = KIND_CTRL;   hdr_len = SHORT_LEN;      end
            HDR_TUNE:   begin k = KIND_TUNE;   hdr_len = TUNE_LEN;       end
            HDR_SENSOR: begin k = KIND_SENSOR; hdr_len = SENSOR_HDR_LEN; end
            HDR_CALIB:  begin k = KIND_CALIB;  hdr_len = SHORT_LEN;      end
            HDR_DIRECT: begin k = KIND_DIRECT; hdr_len = SHORT_LEN;      end
            default: ;
         endcase
         if (hdr_len != 0) begin
            r.consumed   = 1'b1;
            r.frame_kind = k;
            in_frame     = 1'b1;
            cur_kind     = k;
            fill_cnt     = 1;
            frame_len    = hdr_len;
            crc8_acc     = crc8_of(8'h00, b);
            crc16_acc    = crc16_of(16'h0000, b);
            crc16_rx     = '0;
            magic_acc    = (cfg_offset == 0) ? {24'h0, b} : 32'h0;
         end
      end else begin
         r.frame_kind = cur_kind;
         if (fill_cnt >= BUFFER_BYTES) begin
            // frame outgrew the buffer: drop it, byte is not taken
            r.byte_index = fill_cnt[IDX_W-1:0];
            r.frame_end  = 1'b1;
            r.status     = ST_OVERFLOW;
            in_frame     = 1'b0;
            fill_cnt     = 0;
         end else begin
            pos = fill_cnt;
            r.consumed   = 1'b1;
            r.byte_index = pos[IDX_W-1:0];
            fill_cnt     = pos + 1;
            if (cur_kind == KIND_SENSOR && fill_cnt == SENSOR_HDR_LEN)
               frame_len = SENSOR_OVERHEAD + b;
            if (cur_kind == KIND_TUNE) begin
               if (pos >= cfg_offset && pos - cfg_offset < 4)
                  magic_acc |= 32'(b) << (8 * (pos - cfg_offset));
               if (pos == CRC16_SPAN)
                  crc16_rx = {8'h00, b};
               else if (pos == CRC16_SPAN + 1)
                  crc16_rx[15:8] = b;
            end
            if (fill_cnt >= frame_len) begin
               r.frame_end = 1'b1;
               in_frame    = 1'b0;
               if (cur_kind == KIND_TUNE) begin
                  if (magic_acc != cfg_magic)
                     r.status = ST_MAGIC;
                  else if (b != TUNE_TAIL)
                     r.status = ST_TAIL;
                  else if (crc16_rx != crc16_acc)
                     r.status = ST_CRC16;
               end else if (cur_kind == KIND_SENSOR) begin
                  if (crc8_acc != b)
                     r.status = ST_CRC8;
               end
               if (r.status == ST_OK)
                  good_cnt = good_cnt + 16'd1;
               else
                  bad_cnt = bad_cnt + 16'd1;
            end
            crc8_acc = crc8_of(crc8_acc, b);
            if (pos < CRC16_SPAN)
               crc16_acc = crc16_of(crc16_acc, b);
         end
      end
      r.good_frames = good_cnt;
      r.bad_frames  = bad_cnt;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTS)
         $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   rsp_type got;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         parser_reset();
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAGIC_WORD:   cfg_magic  = csr_data;
               CSR_MAGIC_OFFSET: cfg_offset = csr_data[OFFS_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(parse_byte(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.consumed    = rsp_tuser[0];
            got.frame_kind  = kind_type'(rsp_tuser[3:1]);
            got.byte_index  = rsp_tdata[5:0];
            got.byte_value  = rsp_tdata[13:6];
            got.frame_end   = rsp_tlast;
            got.status      = status_type'(rsp_tdata[16:14]);
            got.good_frames = rsp_tdata[32:17];
            got.bad_frames  = rsp_tdata[48:33];
            if (pending_results.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = pending_results.pop_front();
               if (got.consumed !== want.consumed)
                  report_mismatch($sformatf("consumed %0b, want %0b",
                                            got.consumed, want.consumed));
               if (got.frame_kind !== want.frame_kind)
                  report_mismatch($sformatf("frame_kind %0d, want %0d",
                                            got.frame_kind, want.frame_kind));
               if (got.byte_index !== want.byte_index)
                  report_mismatch($sformatf("byte_index %0d, want %0d",
                                            got.byte_index, want.byte_index));
               if (got.byte_value !== want.byte_value)
                  report_mismatch($sformatf("byte_value %02h, want %02h",
                                            got.byte_value, want.byte_value));
               if (got.frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end %0b, want %0b",
                                            got.frame_end, want.frame_end));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            got.status, want.status));
               if (got.good_frames !== want.good_frames)
                  report_mismatch($sformatf("good_frames %0d, want %0d",
                                            got.good_frames, want.good_frames));
               if (got.bad_frames !== want.bad_frames)
                  report_mismatch($sformatf("bad_frames %0d, want %0d",
                                            got.bad_frames, want.bad_frames));
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver stalls
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             stall_tick = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         STALL_NONE:     rsp_tready <= 1'b1;
         STALL_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_tready <= (stall_tick % 5 != 0);
         STALL_HEAVY:    rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // ---------------------------------------------------------------- drivers
   // all drivers start and end on a falling edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_items++;
   endtask

   task automatic send_frame(input int n);
      for (int i = 0; i < n && i < frame_q.size(); i++)
         send_byte(frame_q[i]);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      if (last)
         csr_valid <= 1'b0;
   endtask

   task automatic set_magic(input logic [31:0] word, input logic [OFFS_W-1:0] off);
      logic [31:0] off_data;
      off_data = $urandom;
      off_data[OFFS_W-1:0] = off;
      wait_idle();
      csr_write(CSR_MAGIC_WORD, word, 1'b0);
      csr_write(CSR_MAGIC_OFFSET, off_data, 1'b1);
   endtask

   // ---------------------------------------------------------------- frame builders
   task automatic build_short(input logic [7:0] hdr);
      frame_q.delete();
      frame_q.push_back(hdr);
      frame_q.push_back(8'($urandom));
   endtask

   task automatic build_sensor(input int len, input bit bad_crc);
      logic [7:0] crc;
      frame_q.delete();
      frame_q.push_back(HDR_SENSOR);
      frame_q.push_back(8'($urandom));
      frame_q.push_back(8'(len));
      for (int i = 0; i < len; i++)
         frame_q.push_back(8'($urandom));
      crc = 8'h00;
      foreach (frame_q[i])
         crc = crc8_of(crc, frame_q[i]);
      if (bad_crc)
         crc ^= 8'(1 << $urandom_range(0, 7));
      frame_q.push_back(crc);
   endtask

   // builds against the current register values: only the chosen fault fails for offsets 1-26
   task automatic build_tuning(input tune_fault_type fault);
      logic [15:0] crc;
      int          p;
      frame_q.delete();
      frame_q.push_back(HDR_TUNE);
      for (int i = 1; i < TUNE_BYTES; i++)
         frame_q.push_back(8'($urandom));
      for (int i = 0; i < 4; i++)
         if (cfg_offset + i >= 1 && cfg_offset + i < CRC16_SPAN)
            frame_q[cfg_offset + i] = cfg_magic[8*i +: 8];
      if (fault == FAULT_MAGIC) begin
         p = cfg_offset + $urandom_range(0, 3);
         if (p >= 1 && p < CRC16_SPAN)
            frame_q[p] ^= 8'(1 << $urandom_range(0, 7));
      end
      crc = 16'h0000;
      for (int i = 0; i < CRC16_SPAN; i++)
         crc = crc16_of(crc, frame_q[i]);
      frame_q[CRC16_SPAN]     = crc[7:0];
      frame_q[CRC16_SPAN + 1] = crc[15:8];
      frame_q[TUNE_BYTES - 1] = TUNE_TAIL;
      case (fault)
         FAULT_TAIL:
            frame_q[TUNE_BYTES - 1] ^= 8'(1 << $urandom_range(0, 7));
         FAULT_CRC:
            frame_q[CRC16_SPAN + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
         FAULT_GARBLE:
            repeat ($urandom_range(1, 4))
               frame_q[$urandom_range(1, TUNE_BYTES - 1)] = 8'($urandom);
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_headers_and_noise();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_byte(8'hFD);
      send_byte(HDR_CTRL);   send_byte(8'h00);
      send_byte(HDR_CALIB);  send_byte(8'hFF);
      send_byte(HDR_DIRECT); send_byte(8'h80);
      // header value inside a frame is plain payload
      send_byte(HDR_CTRL);   send_byte(HDR_TUNE);
      build_sensor(0, 1'b0);
      send_frame(frame_q.size());
      build_sensor(0, 1'b1);
      send_frame(frame_q.size());
      send_byte(8'h01);
   endtask

   task automatic test_tuning_frames();
      build_tuning(FAULT_NONE);   send_frame(TUNE_BYTES);
      build_tuning(FAULT_TAIL);   send_frame(TUNE_BYTES);
      build_tuning(FAULT_CRC);    send_frame(TUNE_BYTES);
   endtask

   task automatic test_sensor_frames();
      build_sensor(1, 1'b0);
      send_frame(frame_q.size());
      build_sensor(2, 1'b1);
      send_frame(frame_q.size());
      build_sensor(SENSOR_FIT, 1'b0);
      send_frame(frame_q.size());
   endtask

   task automatic test_buffer_overflow();
      build_sensor(SENSOR_FIT + 1, 1'b0);
      send_frame(frame_q.size());
      // longest length byte; cut off a little after the drop
      build_sensor(255, 1'b0);
      send_frame(SENSOR_FIT + 6);
      build_short(HDR_DIRECT);
      send_frame(2);
   endtask

   task automatic test_magic_settings();
      logic [31:0] words[6];
      logic [4:0]  offs[6];
      words = '{32'h0000_0000, 32'hFFFF_FFFF, {24'($urandom), HDR_TUNE},
                32'($urandom), 32'($urandom), 32'($urandom)};
      offs  = '{5'd1, 5'd26, 5'd0, 5'd27, 5'd31, 5'($urandom_range(1, 26))};
      foreach (words[i]) begin
         set_magic(words[i], offs[i]);
         if (i == 5) begin
            csr_write(CSR_SPARE_2, $urandom, 1'b0);
            csr_write(CSR_SPARE_3, $urandom, 1'b1);
         end
         build_tuning((i == 1 || i == 3) ? FAULT_MAGIC : FAULT_NONE);
         send_frame(TUNE_BYTES);
      end
      set_magic(MAGIC_WORD_RST, MAGIC_OFFSET_RST);
   endtask

   task automatic test_random_traffic();
      int start;
      int pick;
      int len;
      start = sent_items;
      while (sent_items - start < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_byte(8'($urandom));
         end else if (pick < 38) begin
            case ($urandom_range(0, 2))
               0: build_short(HDR_CTRL);
               1: build_short(HDR_CALIB);
               default: build_short(HDR_DIRECT);
            endcase
            send_frame(2);
         end else if (pick < 70) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(SENSOR_FIT - 2, SENSOR_FIT + 8)
                                               : $urandom_range(0, 12);
            build_sensor(len, $urandom_range(0, 3) == 0);
            send_frame(frame_q.size());
         end else if (pick < 92) begin
            if ($urandom_range(0, 1) == 0)
               build_tuning(FAULT_NONE);
            else
               build_tuning(tune_fault_type'($urandom_range(1, 4)));
            send_frame(TUNE_BYTES);
         end else begin
            // cut-off frame: the next header lands inside it
            build_tuning(FAULT_NONE);
            send_frame($urandom_range(1, TUNE_BYTES - 1));
         end
         if ($urandom_range(0, 39) == 0)
            set_magic($urandom, ($urandom_range(0, 4) == 0) ? 5'($urandom)
                                                           : 5'($urandom_range(1, 26)));
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_headers_and_noise();
      test_tuning_frames();
      test_sensor_frames();
      test_buffer_overflow();
      test_magic_settings();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/sfrc_pkg.sv
hw/rtl/serial_frame_receiver_checker_top.sv
tb/testbench.sv
